[sv/sparse_table_2d_range_max_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 2-D sparse table
// Concurrent assertion wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TABLE_2D_RANGE_MAX_MACROS_SVH
`define SPARSE_TABLE_2D_RANGE_MAX_MACROS_SVH
`ifndef SYNTHESIS
`define ST_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ST_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ST_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define ST_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

[sv/st2d_pkg.sv]
// ----------------------------------------------------------------------------
// st2d_pkg
// Shared constants, types and helpers of the 2-D sparse table.
// ----------------------------------------------------------------------------
package st2d_pkg;
  localparam int MaxDim    = 16;
  localparam int LogLevels = 5;
  localparam int DimW      = $clog2(MaxDim);
  localparam int LvlW      = $clog2(LogLevels);
  localparam int TblDepth  = LogLevels * MaxDim * LogLevels * MaxDim;
  localparam int AddrW     = $clog2(TblDepth);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef logic [AddrW-1:0] addr_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic        we;
    addr_t       addr;
    logic [31:0] wdata;
  } mem_req_t;

  function automatic addr_t tidx(input logic [LvlW-1:0] x, input logic [DimW-1:0] i,
                                 input logic [LvlW-1:0] y, input logic [DimW-1:0] j);
    logic [AddrW+8:0] k;
    k = (((AddrW+9)'(x) * (AddrW+9)'(MaxDim) + (AddrW+9)'(i)) * (AddrW+9)'(LogLevels)
         + (AddrW+9)'(y)) * (AddrW+9)'(MaxDim) + (AddrW+9)'(j);
    return k[AddrW-1:0];
  endfunction

  function automatic logic [LvlW-1:0] flog2(input logic [5:0] v);
    logic [LvlW-1:0] k;
    k = '0;
    for (int b = 1; b < LogLevels; b++)
      if ((v >> b) != 6'd0) k = LvlW'(b);
    return k;
  endfunction
endpackage

[sv/st2d_ram.sv]
// ----------------------------------------------------------------------------
// st2d_ram
// Single-port table memory with registered read data.
// ----------------------------------------------------------------------------
module st2d_ram (
  input  logic                   clk,
  input  st2d_pkg::mem_req_t     req,
  output logic [31:0]            rdata
);
  import st2d_pkg::*;
  logic [31:0] mem [TblDepth];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    rdata <= mem[req.addr];
  end
endmodule

[sv/st2d_seq.sv]
// ----------------------------------------------------------------------------
// st2d_seq
// Sequencer: loads, the level-by-level build and four-read queries, all
// through one memory port and one signed compare.
// ----------------------------------------------------------------------------
module st2d_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic [4:0]          in_row,
  input  logic [4:0]          in_col,
  input  logic signed [31:0]  in_value,
  input  logic [4:0]          in_row_lo,
  input  logic [4:0]          in_col_lo,
  input  logic [4:0]          in_row_hi,
  input  logic [4:0]          in_col_hi,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data,
  output st2d_pkg::mem_req_t  mreq,
  input  logic [31:0]         mrdata,
  output logic                out_valid,
  output logic                out_result_kind,
  output logic signed [31:0]  out_max_value,
  output logic                out_range_error
);
  import st2d_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RDA, S_RDB, S_CMP, S_WR, S_Q} state_t;

  state_t          state_r;
  logic            built_r;
  logic [4:0]      rows_r, cols_r;
  // Build loop: phase 0 along columns, phase 1 along rows.
  logic            ph_r;
  logic [LvlW-1:0] x_r, y_r;
  logic [DimW:0]   i_r, j_r;
  logic [31:0]     a_r;
  // Query: four reads, counted by q_r; best_r collects the maximum.
  logic [2:0]      q_r;
  logic [LvlW-1:0] kx_r, ky_r;
  logic [DimW-1:0] ra_r, rb_r, ca_r, cb_r;
  logic [31:0]     best_r;

  logic [4:0] cfg_sat;
  assign cfg_sat = (cfg_data > 5'(MaxDim)) ? 5'(MaxDim) : cfg_data;

  // The one compare unit, shared by build and query.
  logic [31:0] cmp_a, cmp_m;
  assign cmp_a = (state_r == S_Q) ? best_r : a_r;
  assign cmp_m = ($signed(cmp_a) >= $signed(mrdata)) ? cmp_a : mrdata;

  // Level extents, a valid step only when 2^lvl fits.
  logic [5:0] hx, hy;
  assign hx = 6'd1 << x_r;
  assign hy = 6'd1 << y_r;

  // Address parts of the current build step's two sources.
  logic [LvlW-1:0] sx, sy;
  logic [DimW:0]   bi, bj;
  assign sx = ph_r ? x_r - 1'b1 : x_r;
  assign sy = ph_r ? y_r : y_r - 1'b1;
  assign bi = ph_r ? i_r + (DimW+1)'(hx >> 1) : i_r;
  assign bj = ph_r ? j_r : j_r + (DimW+1)'(hy >> 1);

  // Next build step.
  logic            nxt_done, nxt_ph;
  logic [LvlW-1:0] nx, ny;
  logic [DimW:0]   ni, nj;
  always_comb begin
    nxt_done = 1'b0;
    nxt_ph = ph_r; nx = x_r; ny = y_r; ni = i_r; nj = j_r + 1'b1;
    if (!ph_r) begin
      // Row i, level y, columns j.
      if (6'(nj) + hy > 6'(cols_r)) begin
        nj = '0;
        if (32'(y_r) + 1 < LogLevels && (hy << 1) <= 6'(cols_r)) ny = y_r + 1'b1;
        else begin
          ny = LvlW'(1);
          ni = i_r + 1'b1;
          if (6'(ni) >= 6'(rows_r)) begin
            nxt_ph = 1'b1; nx = LvlW'(1); ni = '0; ny = '0;
            if (6'd2 > 6'(rows_r) || LogLevels < 2) nxt_done = 1'b1;
          end
        end
      end
    end else begin
      if (6'(nj) + hy > 6'(cols_r)) begin
        nj = '0;
        if (32'(y_r) + 1 < LogLevels && (hy << 1) <= 6'(cols_r)) ny = y_r + 1'b1;
        else begin
          ny = '0;
          ni = i_r + 1'b1;
          if (6'(ni) + hx > 6'(rows_r)) begin
            ni = '0;
            if (32'(x_r) + 1 < LogLevels && (hx << 1) <= 6'(rows_r)) nx = x_r + 1'b1;
            else nxt_done = 1'b1;
          end
        end
      end
    end
  end

  logic phase0_empty;
  assign phase0_empty = (cols_r < 5'd2);

  // Query address pick.
  logic [DimW-1:0] qr, qc;
  assign qr = q_r[1] ? rb_r : ra_r;
  assign qc = q_r[0] ? cb_r : ca_r;

  logic q_bad;
  logic [5:0] rspan, cspan;
  logic [LvlW-1:0] qkx, qky;
  assign q_bad = !built_r || in_row_lo == 5'd0 || in_col_lo == 5'd0 ||
                 in_row_lo > in_row_hi || in_col_lo > in_col_hi ||
                 in_row_hi > rows_r || in_col_hi > cols_r;
  assign rspan = 6'(in_row_hi) - 6'(in_row_lo) + 6'd1;
  assign cspan = 6'(in_col_hi) - 6'(in_col_lo) + 6'd1;
  assign qkx = flog2(rspan);
  assign qky = flog2(cspan);

  always_comb begin
    mreq = '{we: 1'b0, addr: '0, wdata: a_r};
    unique case (state_r)
      S_IDLE: begin
        mreq.we    = start && in_opcode == OP_LOAD && in_row != 5'd0 && in_col != 5'd0 &&
                     in_row <= 5'(MaxDim) && in_col <= 5'(MaxDim);
        mreq.addr  = tidx('0, DimW'(in_row - 5'd1), '0, DimW'(in_col - 5'd1));
        mreq.wdata = in_value;
      end
      S_RDA:  mreq.addr = tidx(sx, DimW'(i_r), sy, DimW'(j_r));
      S_RDB:  mreq.addr = tidx(sx, DimW'(bi), sy, DimW'(bj));
      S_CMP:  mreq.addr = tidx(sx, DimW'(bi), sy, DimW'(bj));
      S_WR: begin
        mreq.we   = 1'b1;
        mreq.addr = tidx(x_r, DimW'(i_r), y_r, DimW'(j_r));
      end
      S_Q:    mreq.addr = tidx(kx_r, qr, ky_r, qc);
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      built_r   <= 1'b0;
      rows_r    <= 5'(MaxDim);
      cols_r    <= 5'(MaxDim);
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        built_r <= 1'b0;
        if (cfg_index == CFG_ROWS) rows_r <= cfg_sat;
        else cols_r <= cfg_sat;
      end
      unique case (state_r)
        S_IDLE: if (start) begin
          unique case (in_opcode)
            OP_LOAD: if (mreq.we) built_r <= 1'b0;
            OP_BUILD: begin
              ph_r <= 1'b0; x_r <= '0; y_r <= LvlW'(1); i_r <= '0; j_r <= '0;
              if (rows_r == 5'd0) begin
                built_r <= 1'b1;
                out_valid <= 1'b1; out_result_kind <= 1'b0;
                out_max_value <= '0; out_range_error <= 1'b0;
              end else if (phase0_empty) begin
                ph_r <= 1'b1; x_r <= LvlW'(1); y_r <= '0;
                if (rows_r < 5'd2 || cols_r == 5'd0) begin
                  built_r <= 1'b1;
                  out_valid <= 1'b1; out_result_kind <= 1'b0;
                  out_max_value <= '0; out_range_error <= 1'b0;
                end else state_r <= S_RDA;
              end else state_r <= S_RDA;
            end
            OP_QUERY: begin
              if (q_bad) begin
                out_valid <= 1'b1; out_result_kind <= 1'b1;
                out_max_value <= '0; out_range_error <= 1'b1;
              end else begin
                kx_r <= qkx; ky_r <= qky;
                ra_r <= DimW'(in_row_lo - 5'd1);
                rb_r <= DimW'(6'(in_row_hi) - (6'd1 << qkx));
                ca_r <= DimW'(in_col_lo - 5'd1);
                cb_r <= DimW'(6'(in_col_hi) - (6'd1 << qky));
                q_r <= '0;
                state_r <= S_Q;
              end
            end
            default: ;
          endcase
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          a_r <= mrdata;
          state_r <= S_CMP;
        end
        S_CMP: begin
          a_r <= cmp_m;
          state_r <= S_WR;
        end
        S_WR: begin
          ph_r <= nxt_ph; x_r <= nx; y_r <= ny; i_r <= ni; j_r <= nj;
          if (nxt_done) begin
            built_r <= 1'b1;
            out_valid <= 1'b1; out_result_kind <= 1'b0;
            out_max_value <= '0; out_range_error <= 1'b0;
            state_r <= S_IDLE;
          end else state_r <= S_RDA;
        end
        S_Q: begin
          // Read data comes back in the cycle after its address.
          q_r <= q_r + 3'd1;
          if (q_r == 3'd1) best_r <= mrdata;
          else if (q_r != 3'd0) best_r <= cmp_m;
          if (q_r == 3'd4) begin
            out_valid <= 1'b1; out_result_kind <= 1'b1;
            out_max_value <= cmp_m; out_range_error <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/sparse_table_2d_range_max.sv]
// ----------------------------------------------------------------------------
// sparse_table_2d_range_max
// Two-dimensional sparse table answering submatrix maximum queries.
// ----------------------------------------------------------------------------
// A load item is written from the idle state. A query makes four reads of the
// single-port table memory, each folded into the running maximum by the one
// signed comparator. A build writes each table entry in four steps (two reads,
// a compare, a write); at full size that is 2660 entries. Results appear on
// out_valid for one cycle and cannot be stalled.
module sparse_table_2d_range_max (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [4:0]         in_row,
  input  logic [4:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_row_lo,
  input  logic [4:0]         in_col_lo,
  input  logic [4:0]         in_row_hi,
  input  logic [4:0]         in_col_hi,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data,
  output logic               out_valid,
  output logic               out_result_kind,
  output logic signed [31:0] out_max_value,
  output logic               out_range_error
);
  import st2d_pkg::*;
`include "sparse_table_2d_range_max_macros.svh"

  mem_req_t    mreq;
  logic [31:0] mrdata;

  assign cfg_ready = 1'b1;

  st2d_seq u_seq (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_row, .in_col, .in_value,
    .in_row_lo, .in_col_lo, .in_row_hi, .in_col_hi,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .mreq, .mrdata, .out_valid, .out_result_kind, .out_max_value, .out_range_error
  );

  st2d_ram u_ram (.clk, .req(mreq), .rdata(mrdata));

  `ST_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_range_error,
                 out_max_value == 32'sd0 && out_result_kind)
  `ST_ASSERT_NXT(a_q_busy, clk, rst_n, start && !busy && in_opcode == OP_LOAD, !busy)
  `ST_ASSERT_IMP(a_nowr_q, clk, rst_n, busy && !mreq.we && out_valid, !out_range_error)
endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for sparse_table_2d_range_max
// Loads the whole matrix and builds the table. Then it sends directed and
// random items, checking results against a table predictor or typed value.
// ----------------------------------------------------------------------------
module tb_top;
  import st2d_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  r, c;
    logic [31:0] v;
    logic [4:0]  rl, cl, rh, ch;
    bit          typed;
    logic        ekind;
    logic [31:0] eval;
    logic        eerr;
  } stim_t;

  typedef struct {
    logic        kind;
    logic [31:0] maxv;
    logic        err;
  } answer_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_opcode;
  logic [4:0] in_row, in_col, in_row_lo, in_col_lo, in_row_hi, in_col_hi;
  logic signed [31:0] in_value;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [4:0] cfg_data;
  logic out_valid, out_result_kind, out_range_error;
  logic signed [31:0] out_max_value;

  sparse_table_2d_range_max u_dut (.*);

  // Predicted table contents and settings.
  logic [31:0] blk [LogLevels][MaxDim][LogLevels][MaxDim];
  bit          built;
  int          n_rows, n_cols;
  answer_t     pending[$];
  int          errors;
  int          sent;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("sparse_table_2d_range_max verification failed");
    $finish;
  end

  function automatic logic [31:0] bigger(logic [31:0] a, logic [31:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic int floor_log(int v);
    int k;
    k = 0;
    while ((v >> 1) != 0 && k + 1 < LogLevels) begin
      v = v >> 1;
      k++;
    end
    return k;
  endfunction

  function automatic void fill_levels();
    for (int i = 0; i < n_rows; i++)
      for (int y = 1; y < LogLevels && (1 << y) <= n_cols; y++)
        for (int j = 0; j + (1 << y) <= n_cols; j++)
          blk[0][i][y][j] = bigger(blk[0][i][y-1][j], blk[0][i][y-1][j + (1 << (y-1))]);
    for (int x = 1; x < LogLevels && (1 << x) <= n_rows; x++)
      for (int i = 0; i + (1 << x) <= n_rows; i++)
        for (int y = 0; y < LogLevels && (1 << y) <= n_cols; y++)
          for (int j = 0; j + (1 << y) <= n_cols; j++)
            blk[x][i][y][j] = bigger(blk[x-1][i][y][j], blk[x-1][i + (1 << (x-1))][y][j]);
    built = 1;
  endfunction

  // Updates the predicted state for one item; returns 1 with the answer if
  // the item produces a result.
  function automatic bit predict(stim_t s, output answer_t a);
    int kx, ky, ra, rb, ca, cb;
    a = '{1'b0, 32'd0, 1'b0};
    case (s.op)
      OP_LOAD: begin
        if (s.r >= 1 && s.r <= MaxDim && s.c >= 1 && s.c <= MaxDim) begin
          blk[0][s.r-1][0][s.c-1] = s.v;
          built = 0;
        end
        return 0;
      end
      OP_BUILD: begin
        fill_levels();
        return 1;
      end
      OP_QUERY: begin
        a.kind = 1'b1;
        if (!built || s.rl == 0 || s.cl == 0 || s.rl > s.rh || s.cl > s.ch ||
            s.rh > n_rows || s.ch > n_cols) begin
          a.err = 1'b1;
          return 1;
        end
        kx = floor_log(s.rh - s.rl + 1);
        ky = floor_log(s.ch - s.cl + 1);
        ra = s.rl - 1;
        rb = s.rh - (1 << kx);
        ca = s.cl - 1;
        cb = s.ch - (1 << ky);
        a.maxv = bigger(bigger(blk[kx][ra][ky][ca], blk[kx][ra][ky][cb]),
                        bigger(blk[kx][rb][ky][ca], blk[kx][rb][ky][cb]));
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  task automatic send(stim_t s, int gap);
    answer_t a;
    in_opcode <= s.op;
    in_row    <= s.r;
    in_col    <= s.c;
    in_value  <= s.v;
    in_row_lo <= s.rl;
    in_col_lo <= s.cl;
    in_row_hi <= s.rh;
    in_col_hi <= s.ch;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    if (predict(s, a)) begin
      if (s.typed) pending.push_back('{s.ekind, s.eval, s.eerr});
      else pending.push_back(a);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    drain();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS) n_rows = (val > MaxDim) ? MaxDim : val;
    else n_cols = (val > MaxDim) ? MaxDim : val;
    built = 0;
  endtask

  function automatic stim_t mk(logic [1:0] op);
    stim_t s;
    s.op = op;
    s.r = 5'($urandom); s.c = 5'($urandom); s.v = $urandom;
    s.rl = 5'($urandom); s.cl = 5'($urandom); s.rh = 5'($urandom); s.ch = 5'($urandom);
    s.typed = 0; s.ekind = 0; s.eval = 0; s.eerr = 0;
    return s;
  endfunction

  function automatic stim_t good_query();
    stim_t s;
    s = mk(OP_QUERY);
    s.rl = 5'($urandom_range(n_rows, 1));
    s.rh = 5'($urandom_range(n_rows, s.rl));
    s.cl = 5'($urandom_range(n_cols, 1));
    s.ch = 5'($urandom_range(n_cols, s.cl));
    return s;
  endfunction

  function automatic stim_t row(logic [1:0] op, int r, int c, logic [31:0] v, int rl, int cl,
                                int rh, int ch, bit typed, logic k, logic [31:0] ev,
                                logic ee);
    return '{op, r[4:0], c[4:0], v, rl[4:0], cl[4:0], rh[4:0], ch[4:0], typed, k, ev, ee};
  endfunction

  // Monitor: results cannot be held off, so each strobe is checked at once.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: kind %0d value %0d error %0d", $time,
                 out_result_kind, out_max_value, out_range_error);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_result_kind !== e.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, e.kind,
                   out_result_kind);
          errors++;
        end
        if (out_max_value !== e.maxv) begin
          $display("%0t: max_value expected %0d actual %0d", $time, $signed(e.maxv),
                   out_max_value);
          errors++;
        end
        if (out_range_error !== e.err) begin
          $display("%0t: range_error expected %0d actual %0d", $time, e.err,
                   out_range_error);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_t early[$];
    stim_t later[$];
    stim_t s;
    int    r, q, nload, nq, waited;
    logic [31:0] v;

    errors = 0; sent = 0; built = 0; n_rows = MaxDim; n_cols = MaxDim;
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = CFG_ROWS; cfg_data = '0;
    in_opcode = OP_LOAD; in_row = '0; in_col = '0; in_value = '0;
    in_row_lo = '0; in_col_lo = '0; in_row_hi = '0; in_col_hi = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before anything is built: queries are flagged, stray items ignored.
    early.push_back(row(OP_QUERY, 0, 0, 0, 1, 1, 16, 16, 1, 1, 0, 1));
    early.push_back(row(OP_SPARE, 3, 3, 32'hFFFF_FFFF, 1, 1, 1, 1, 0, 0, 0, 0));
    early.push_back(row(OP_LOAD, 0, 5, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0, 0));
    early.push_back(row(OP_LOAD, 31, 31, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    early.push_back(row(OP_LOAD, 17, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (early[i]) send(early[i], pick_gap());

    // Every element is written before the first build.
    for (int i = 1; i <= MaxDim; i++)
      for (int j = 1; j <= MaxDim; j++) begin
        v = $urandom;
        if (i == 1 && j == 1) v = 32'h8000_0000;
        if (i == 16 && j == 16) v = 32'h7FFF_FFFF;
        send(row(OP_LOAD, i, j, v, 0, 0, 0, 0, 0, 0, 0, 0), pick_gap());
      end

    later.push_back(row(OP_BUILD, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    later.push_back(row(OP_QUERY, 0, 0, 0, 1, 1, 16, 16, 1, 1, 32'h7FFF_FFFF, 0));
    later.push_back(row(OP_QUERY, 0, 0, 0, 1, 1, 1, 1, 1, 1, 32'h8000_0000, 0));
    later.push_back(row(OP_QUERY, 0, 0, 0, 16, 16, 16, 16, 1, 1, 32'h7FFF_FFFF, 0));
    later.push_back(row(OP_QUERY, 0, 0, 0, 3, 2, 5, 7, 0, 0, 0, 0));
    later.push_back(row(OP_QUERY, 0, 0, 0, 2, 9, 15, 16, 0, 0, 0, 0));
    later.push_back(row(OP_QUERY, 0, 0, 0, 0, 1, 4, 4, 1, 1, 0, 1));
    later.push_back(row(OP_QUERY, 0, 0, 0, 1, 0, 4, 4, 1, 1, 0, 1));
    later.push_back(row(OP_QUERY, 0, 0, 0, 5, 1, 4, 4, 1, 1, 0, 1));
    later.push_back(row(OP_QUERY, 0, 0, 0, 1, 5, 4, 4, 1, 1, 0, 1));
    later.push_back(row(OP_QUERY, 0, 0, 0, 1, 1, 17, 4, 1, 1, 0, 1));
    later.push_back(row(OP_QUERY, 0, 0, 0, 1, 1, 4, 31, 1, 1, 0, 1));
    later.push_back(row(OP_LOAD, 8, 8, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    later.push_back(row(OP_QUERY, 0, 0, 0, 1, 1, 2, 2, 1, 1, 0, 1));
    later.push_back(row(OP_BUILD, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    later.push_back(row(OP_QUERY, 0, 0, 0, 8, 8, 8, 8, 1, 1, 32'h7FFF_FFFF, 0));
    foreach (later[i]) send(later[i], pick_gap());

    // A register write after a build leaves the table unbuilt.
    write_reg(CFG_ROWS, 5'd16);
    send(row(OP_QUERY, 0, 0, 0, 1, 1, 1, 1, 1, 1, 0, 1), 0);
    send(row(OP_BUILD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);

    // Random phases: optional settings, a few loads, a build, then queries and spare items.
    for (int ph = 0; sent < 560; ph++) begin
      if (ph % 4 == 1) begin
        case (ph / 4)
          0: begin write_reg(CFG_ROWS, 5'd1);  write_reg(CFG_COLS, 5'd1);  end
          1: begin write_reg(CFG_ROWS, 5'd0);  write_reg(CFG_COLS, 5'd16); end
          2: begin write_reg(CFG_ROWS, 5'd31); write_reg(CFG_COLS, 5'd0);  end
          3: begin write_reg(CFG_ROWS, 5'd16); write_reg(CFG_COLS, 5'd31); end
          default: begin
            write_reg(CFG_ROWS, 5'($urandom_range(12, 1)));
            write_reg(CFG_COLS, 5'($urandom_range(12, 1)));
          end
        endcase
      end
      if (ph == 6) drain();
      r = $urandom_range(1);
      nload = $urandom_range(5);
      for (int i = 0; i < nload; i++) begin
        s = mk(OP_LOAD);
        if ($urandom_range(9) != 0) begin
          s.r = 5'($urandom_range(MaxDim, 1));
          s.c = 5'($urandom_range(MaxDim, 1));
        end
        send(s, r ? 0 : pick_gap());
      end
      send(mk(OP_BUILD), r ? 0 : pick_gap());
      nq = $urandom_range(24, 10);
      for (int i = 0; i < nq; i++) begin
        q = $urandom_range(99);
        if (n_rows == 0 || n_cols == 0 || q < 12) s = mk(OP_QUERY);
        else if (q < 15) s = mk(OP_SPARE);
        else s = good_query();
        send(s, r ? 0 : pick_gap());
      end
    end

    start <= 1'b0;
    waited = 0;
    while (pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending.size() == 0)
      $display("sparse_table_2d_range_max verification clean");
    else
      $display("sparse_table_2d_range_max verification failed");
    $finish;
  end
endmodule
